// ===== hdl/selective_repeat_receive_window_defines.svh =====
// Assertion macros used by the receive window top level.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SRRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/srrw_pkg.sv =====
// Shared types and constants of the selective-repeat receive window.
package srrw_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 32;
  localparam int SEQ_W = 16;
  localparam int LEN_W = 11;
  localparam int TAG_W = 16;
  localparam int CFG_W = 6;
  localparam logic [LEN_W-1:0] PAYLOAD_MAX = 11'd1024;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 6'd32;

  localparam logic [1:0] OP_SYN  = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_FIN  = 2'd2;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_SYN_ACK = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;
  localparam logic [1:0] KIND_FIN_ACK = 2'd3;

  typedef struct packed {
    logic             arrived;
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic write;
    logic trim;
  } cell_ctrl_t;

endpackage

// ===== hdl/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window for one connection.
//
// Packets enter on the s_ stream, one beat per packet, the kind in s_tuser.
// Results leave on the m_ stream; m_tlast marks the final result of a packet.
// The window size register is to be written through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce it. A SYN or FIN is
// accepted, and the output register is then loaded from the emit state. A
// data packet is accepted and stored; then each released slot is sent as the
// slot row shifts toward the base, the head is found empty and the ACK is
// loaded. Packets that cause no result are only accepted. Delivery runs
// through the slot row one entry per cycle while the output register is free.
// A packet is accepted only while no earlier packet is still at work; a new
// packet is taken while the last result still waits in the output register.
// When the receiver stalls, the block holds its result and waits with it.
// Reset closes the connection, clears all arrival marks at once, zeroes the
// window base and sets the window size to 32; no clearing pass is needed.
`include "selective_repeat_receive_window_defines.svh"

module selective_repeat_receive_window #(
  parameter int WINDOW_DEPTH = srrw_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // seq[15:0], payload_length[26:16], payload_tag[42:27], zero fill above
  input  logic [47:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // number[15:0], out_length[26:16], out_tag[42:27], advertised_window[48:43],
  // zero fill above
  output logic [55:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [srrw_pkg::CFG_W-1:0] cfg_wr_data
);
  import srrw_pkg::*;

  localparam int OFS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WIN_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELIVER,
    ST_EMIT
  } state_t;

  state_t           state;
  logic             connected;
  logic [SEQ_W-1:0] window_base;
  logic [SEQ_W-1:0] last_acked;
  logic [CFG_W-1:0] window_size;
  logic [1:0]       pend_kind;
  logic [SEQ_W-1:0] pend_number;
  logic [SEQ_W-1:0] out_number;
  logic [LEN_W-1:0] out_length;
  logic [TAG_W-1:0] out_tag;
  logic [CFG_W-1:0] out_adv;

  logic [1:0]       in_op;
  logic [SEQ_W-1:0] in_seq;
  logic [LEN_W-1:0] in_len_raw;
  logic [LEN_W-1:0] in_len;
  logic [TAG_W-1:0] in_tag;
  logic [WIN_W-1:0] eff_w;
  logic [SEQ_W-1:0] seq_ofs;
  logic             in_window;
  logic             is_old;
  logic             accept;
  logic             out_free;
  logic             load_out;
  cell_ctrl_t       ctrl;
  slot_t            wr_slot;
  slot_t            head;

  assign in_op      = s_tuser;
  assign in_seq     = s_tdata[15:0];
  assign in_len_raw = s_tdata[26:16];
  assign in_tag     = s_tdata[42:27];
  assign in_len     = (in_len_raw > PAYLOAD_MAX) ? PAYLOAD_MAX : in_len_raw;

  always_comb begin
    if (window_size == '0) begin
      eff_w = WIN_W'(1);
    end else if (window_size > CFG_W'(WINDOW_DEPTH)) begin
      eff_w = WIN_W'(WINDOW_DEPTH);
    end else begin
      eff_w = window_size[WIN_W-1:0];
    end
  end

  // Modular offset from the base; the upper half of the space is behind it.
  assign seq_ofs   = in_seq - window_base;
  assign in_window = seq_ofs < SEQ_W'(eff_w);
  assign is_old    = seq_ofs[SEQ_W-1];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // A new beat is loaded into the output register in this cycle.
  assign load_out = ((state == ST_DELIVER) && head.arrived && out_free) ||
                    ((state == ST_EMIT) && out_free);

  always_comb begin
    ctrl.clear = accept && ((in_op == OP_SYN) || ((in_op == OP_FIN) && connected));
    ctrl.trim  = accept && (in_op == OP_DATA) && connected;
    ctrl.write = ctrl.trim && in_window;
    ctrl.shift = (state == ST_DELIVER) && head.arrived && out_free;
    wr_slot.arrived = 1'b1;
    wr_slot.length  = in_len;
    wr_slot.tag     = in_tag;
  end

  srrw_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .wr_ofs  (seq_ofs[OFS_W-1:0]),
    .win     (eff_w),
    .wr_slot (wr_slot),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      connected   <= 1'b0;
      window_base <= '0;
      last_acked  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_SYN: begin
                connected   <= 1'b1;
                window_base <= in_seq + SEQ_W'(1);
                last_acked  <= in_seq;
                pend_kind   <= KIND_SYN_ACK;
                pend_number <= in_seq;
                state       <= ST_EMIT;
              end
              OP_DATA: begin
                if (connected) begin
                  if (in_window) begin
                    state <= ST_DELIVER;
                  end else begin
                    if (is_old) begin
                      last_acked <= in_seq;
                    end
                    pend_kind   <= KIND_ACK;
                    pend_number <= is_old ? in_seq : last_acked;
                    state       <= ST_EMIT;
                  end
                end
              end
              OP_FIN: begin
                if (connected) begin
                  connected   <= 1'b0;
                  pend_kind   <= KIND_FIN_ACK;
                  pend_number <= in_seq;
                  state       <= ST_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DELIVER: begin
          if (!head.arrived) begin
            pend_kind   <= KIND_ACK;
            pend_number <= last_acked;
            state       <= ST_EMIT;
          end else if (out_free) begin
            m_tvalid    <= 1'b1;
            m_tuser     <= KIND_DELIVER;
            m_tlast     <= 1'b0;
            out_number  <= window_base;
            out_length  <= head.length;
            out_tag     <= head.tag;
            out_adv     <= '0;
            last_acked  <= window_base;
            window_base <= window_base + SEQ_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tuser    <= pend_kind;
            m_tlast    <= 1'b1;
            out_number <= pend_number;
            out_length <= '0;
            out_tag    <= '0;
            out_adv    <= CFG_W'(eff_w);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0, out_adv, out_tag, out_length, out_number};

  `SRRW_ASSERT_NOW(a_last_on_ack, m_tvalid, m_tlast == (m_tuser != KIND_DELIVER), "bad tlast")
  `SRRW_ASSERT_NEXT(a_base_step, ctrl.shift, window_base == $past(window_base) + SEQ_W'(1), "base skip")
  `SRRW_ASSERT_NEXT(a_store_deliver, ctrl.write, state == ST_DELIVER && !s_tready, "bad store")

endmodule

// ===== hdl/srrw_cell.sv =====
// One receive slot: holds a packet handle and shifts it toward the window base.
module srrw_cell (
  input  logic               clk,
  input  logic               rst,
  input  srrw_pkg::cell_ctrl_t ctrl,
  input  srrw_pkg::slot_t    upper,
  input  srrw_pkg::slot_t    wr_slot,
  output srrw_pkg::slot_t    slot
);
  import srrw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.arrived <= 1'b0;
    end else if (ctrl.clear) begin
      slot.arrived <= 1'b0;
    end else if (ctrl.shift) begin
      slot.arrived <= upper.arrived;
    end else if (ctrl.write) begin
      slot.arrived <= 1'b1;
    end else if (ctrl.trim) begin
      slot.arrived <= 1'b0;
    end

    if (ctrl.shift) begin
      slot.length <= upper.length;
      slot.tag    <= upper.tag;
    end else if (ctrl.write) begin
      slot.length <= wr_slot.length;
      slot.tag    <= wr_slot.tag;
    end
  end

endmodule

// ===== hdl/srrw_chain.sv =====
// Row of receive slots indexed by offset from the window base.
module srrw_chain #(
  parameter int WINDOW_DEPTH = srrw_pkg::WINDOW_DEPTH_DEFAULT,
  localparam int OFS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int WIN_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srrw_pkg::cell_ctrl_t ctrl,
  input  logic [OFS_W-1:0]     wr_ofs,
  input  logic [WIN_W-1:0]     win,
  input  srrw_pkg::slot_t      wr_slot,
  output srrw_pkg::slot_t      head
);
  import srrw_pkg::*;

  slot_t slots [WINDOW_DEPTH+1];

  // The slot past the end feeds an empty entry in on every shift.
  assign slots[WINDOW_DEPTH] = '0;
  assign head = slots[0];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    cell_ctrl_t cc;

    always_comb begin
      cc.clear = ctrl.clear;
      cc.shift = ctrl.shift;
      cc.write = ctrl.write && (wr_ofs == OFS_W'(i));
      cc.trim  = ctrl.trim && (win <= WIN_W'(i));
    end

    srrw_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cc),
      .upper   (slots[i+1]),
      .wr_slot (wr_slot),
      .slot    (slots[i])
    );
  end

endmodule
